/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in the same cycle as the consequent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/ple_pkg.sv */
package ple_pkg;

  localparam logic [2:0] MODE_INSERT     = 3'd0;
  localparam logic [2:0] MODE_REM_AT     = 3'd1;
  localparam logic [2:0] MODE_RETRIEVE   = 3'd2;
  localparam logic [2:0] MODE_REM_UNIQUE = 3'd3;
  localparam logic [2:0] MODE_REM_LAST   = 3'd4;
  localparam logic [2:0] MODE_REM_ALL    = 3'd5;
  localparam logic [2:0] MODE_CLEAR      = 3'd6;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_RANGE  = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_MULTI  = 3'd3;
  localparam logic [2:0] ST_ABSENT = 3'd4;

  typedef struct packed {
    logic [2:0]  mode;
    logic [4:0]  position;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] value_out;
    logic [4:0]  length;
    logic [4:0]  removed;
  } rsp_t;

endpackage

/* rtl/core/ple_ram.sv */
module ple_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/positional_list_engine.sv */
// Clear, unused mode, range/overflow errors and value commands on an empty list answer
// straight from idle; the result is registered at the accept edge. Insert, remove at, retrieve
// and value removal walk the RAM in busy phases, with one RAM read and one write per cycle.
// Busy drops as the result shows; the next transaction is taken at the edge that ends it.
// Sync reset empties the list (length 0); storage is not cleared. The receiver cannot stall.
module positional_list_engine import ple_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output rsp_t result
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = (CW > 5) ? CW : 5;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_INS  = 2'd1;
  localparam logic [1:0] PH_TAKE = 2'd2;
  localparam logic [1:0] PH_SCAN = 2'd3;

  logic [1:0]             phase;
  logic [2:0]             mode_r;
  logic [IW-1:0]          pos_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [CW-1:0]          count;
  logic [IW-1:0]          rd_ptr;
  logic [CW-1:0]          rem;
  logic                   pend;
  logic [IW-1:0]          pend_ptr;
  logic [IW-1:0]          base;
  logic [CW-1:0]          widx;
  logic [CW-1:0]          gone;
  logic [1:0]             hits;
  logic [IW-1:0]          last;
  logic [15:0]            vout;

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic [VALUE_WIDTH-1:0] rdata;
  logic                   match;
  logic                   loop_end;

  logic [PW-1:0]          pos_w;
  logic [PW-1:0]          cnt_w;
  logic [IW-1:0]          pos_i;
  logic [CW-1:0]          pos_c;

  function automatic rsp_t mk_rsp(input logic [2:0] st, input logic [15:0] v,
                                  input logic [CW-1:0] len, input logic [CW-1:0] gn);
    rsp_t r;
    r.status    = st;
    r.value_out = v;
    r.length    = 5'(len);
    r.removed   = 5'(gn);
    return r;
  endfunction

  ple_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  assign busy     = (phase != PH_IDLE);
  assign match    = (rdata == val_r);
  assign loop_end = !pend && (rem == '0);
  assign pos_w    = PW'(cmd.position);
  assign cnt_w    = PW'(count);
  assign pos_i    = pos_w[IW-1:0];
  assign pos_c    = pos_w[CW-1:0];

  // RAM write port: data read last cycle shifts up on insert, down on take, or compacts.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_ptr;
    ram_wdata = rdata;
    case (phase)
      PH_INS: begin
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = pend_ptr + IW'(1);
        end else if (rem == '0) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = val_r;
        end
      end
      PH_TAKE: begin
        if (pend && (pend_ptr != base)) begin
          ram_we    = 1'b1;
          ram_waddr = pend_ptr - IW'(1);
        end
      end
      PH_SCAN: begin
        // remove-all compaction keeps non-matching entries
        if (pend && (mode_r == MODE_REM_ALL) && !match) begin
          ram_we    = 1'b1;
          ram_waddr = widx[IW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;

      // read issue, one entry per cycle while reads remain
      if (phase != PH_IDLE) begin
        if (rem != '0) begin
          rem      <= rem - CW'(1);
          pend     <= 1'b1;
          pend_ptr <= rd_ptr;
          rd_ptr   <= (phase == PH_INS) ? rd_ptr - IW'(1) : rd_ptr + IW'(1);
        end else begin
          pend <= 1'b0;
        end
      end

      case (phase)
        PH_IDLE: begin
          if (start) begin
            mode_r <= cmd.mode;
            pos_r  <= pos_i;
            val_r  <= VALUE_WIDTH'(cmd.value);
            gone   <= '0;
            vout   <= '0;
            hits   <= '0;
            widx   <= '0;
            pend   <= 1'b0;
            case (cmd.mode)
              MODE_INSERT: begin
                if (pos_w > cnt_w) begin
                  done   <= 1'b1;
                  result <= mk_rsp(ST_RANGE, '0, count, '0);
                end else if (count == CW'(CAPACITY)) begin
                  done   <= 1'b1;
                  result <= mk_rsp(ST_FULL, '0, count, '0);
                end else begin
                  phase  <= PH_INS;
                  rd_ptr <= IW'(count - CW'(1));
                  rem    <= count - pos_c;
                end
              end
              MODE_REM_AT, MODE_RETRIEVE: begin
                if (pos_w >= cnt_w) begin
                  done   <= 1'b1;
                  result <= mk_rsp(ST_RANGE, '0, count, '0);
                end else begin
                  phase  <= PH_TAKE;
                  rd_ptr <= pos_i;
                  base   <= pos_i;
                  rem    <= (cmd.mode == MODE_RETRIEVE) ? CW'(1) : count - pos_c;
                end
              end
              MODE_REM_UNIQUE, MODE_REM_LAST, MODE_REM_ALL: begin
                if (count == '0) begin
                  done   <= 1'b1;
                  result <= mk_rsp((cmd.mode == MODE_REM_ALL) ? ST_OK : ST_ABSENT,
                                   '0, count, '0);
                end else begin
                  phase  <= PH_SCAN;
                  rd_ptr <= '0;
                  rem    <= count;
                end
              end
              MODE_CLEAR: begin
                done   <= 1'b1;
                result <= mk_rsp(ST_OK, '0, '0, count);
                count  <= '0;
              end
              default: begin
                done   <= 1'b1;
                result <= mk_rsp(ST_RANGE, '0, count, '0);
              end
            endcase
          end
        end

        PH_INS: begin
          if (loop_end) begin
            count  <= count + CW'(1);
            done   <= 1'b1;
            result <= mk_rsp(ST_OK, '0, count + CW'(1), '0);
            phase  <= PH_IDLE;
          end
        end

        PH_TAKE: begin
          if (pend && (pend_ptr == base)) begin
            vout <= 16'(rdata);
          end
          if (loop_end) begin
            done  <= 1'b1;
            phase <= PH_IDLE;
            if (mode_r == MODE_RETRIEVE) begin
              result <= mk_rsp(ST_OK, vout, count, '0);
            end else begin
              count  <= count - CW'(1);
              result <= mk_rsp(ST_OK, vout, count - CW'(1), CW'(1));
            end
          end
        end

        PH_SCAN: begin
          if (pend) begin
            if (match) begin
              hits <= (hits == 2'd0) ? 2'd1 : 2'd2;
              last <= pend_ptr;
              gone <= gone + CW'(1);
            end else begin
              widx <= widx + CW'(1);
            end
          end
          if (loop_end) begin
            if (mode_r == MODE_REM_ALL) begin
              count  <= widx;
              done   <= 1'b1;
              result <= mk_rsp(ST_OK, (gone != '0) ? 16'(val_r) : 16'd0, widx, gone);
              phase  <= PH_IDLE;
            end else if ((mode_r == MODE_REM_UNIQUE) && (hits == 2'd2)) begin
              done   <= 1'b1;
              result <= mk_rsp(ST_MULTI, '0, count, '0);
              phase  <= PH_IDLE;
            end else if (hits == 2'd0) begin
              done   <= 1'b1;
              result <= mk_rsp(ST_ABSENT, '0, count, '0);
              phase  <= PH_IDLE;
            end else begin
              // close the gap at the chosen match
              phase  <= PH_TAKE;
              rd_ptr <= last;
              base   <= last;
              rem    <= count - CW'(last);
            end
          end
        end

        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/ple_checker.sv */
`include "assert_macros.svh"

module ple_checker import ple_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t result
);

  // an accepted transaction either answers at once or keeps the block busy
  `ASSERT_NEXT(a_accept_progress, clk, rst, start && !busy, busy || done)

  // leaving busy always delivers the result in the same cycle
  `ASSERT_IMPLIES(a_fall_done, clk, rst, $fell(busy), done)

  `ASSERT_IMPLIES(a_err_no_remove, clk, rst, done && result.status != ST_OK, result.removed == '0)

  `ASSERT_IMPLIES(a_range_no_value, clk, rst, done && result.status == ST_RANGE, result.value_out == '0)

endmodule

bind positional_list_engine ple_checker u_ple_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import ple_pkg::*;

  localparam int          LIST_CAP    = 16;
  localparam logic [2:0]  MODE_UNUSED = 3'd7;
  localparam int          N_PHASES    = 8;
  localparam int          PHASE_ITEMS = 140;

  typedef struct {
    cmd_t c;
    bit   typed;
    rsp_t r;
  } dir_row_t;

  logic clk;
  logic rst   = 1'b1;
  logic start = 1'b0;
  cmd_t cmd   = '0;
  logic busy;
  logic done;
  rsp_t result;

  // shadow copy of the list
  logic [15:0] list_mem [LIST_CAP];
  int          list_len = 0;

  rsp_t        pending_rsp_q[$];
  rsp_t        want;
  int          err_count = 0;
  logic [15:0] val_pool [6];
  dir_row_t    dir_rows [25];

  positional_list_engine u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    err_count++;
  endtask

  function automatic logic [15:0] take_entry(input int idx);
    logic [15:0] v;
    int i;
    v = list_mem[idx];
    for (i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
    list_len--;
    return v;
  endfunction

  function automatic rsp_t predict_list_cmd(input cmd_t c);
    rsp_t r;
    int   i, hits, last_idx, w, gone;
    r    = '0;
    gone = 0;
    case (c.mode)
      MODE_INSERT: begin
        if (c.position > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= LIST_CAP) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i > c.position; i--) list_mem[i] = list_mem[i - 1];
          list_mem[c.position] = c.value;
          list_len++;
        end
      end
      MODE_REM_AT: begin
        if (c.position >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.value_out = take_entry(c.position);
          gone = 1;
        end
      end
      MODE_RETRIEVE: begin
        if (c.position >= list_len) r.status = ST_RANGE;
        else r.value_out = list_mem[c.position];
      end
      MODE_REM_UNIQUE, MODE_REM_LAST: begin
        hits     = 0;
        last_idx = 0;
        for (i = 0; i < list_len; i++) begin
          if (list_mem[i] == c.value) begin
            hits++;
            last_idx = i;
          end
        end
        if (hits == 0) begin
          r.status = ST_ABSENT;
        end else if (hits > 1 && c.mode == MODE_REM_UNIQUE) begin
          r.status = ST_MULTI;
        end else begin
          r.value_out = take_entry(last_idx);
          gone = 1;
        end
      end
      MODE_REM_ALL: begin
        w = 0;
        for (i = 0; i < list_len; i++) begin
          if (list_mem[i] == c.value) gone++;
          else list_mem[w++] = list_mem[i];
        end
        list_len = w;
        if (gone != 0) r.value_out = c.value;
      end
      MODE_CLEAR: begin
        gone     = list_len;
        list_len = 0;
      end
      default: r.status = ST_RANGE;
    endcase
    r.length  = list_len[4:0];
    r.removed = gone[4:0];
    return r;
  endfunction

  function automatic dir_row_t row_typed(input logic [2:0] m, input int p, input int v,
                                         input logic [2:0] st, input int vo, input int l,
                                         input int rm);
    dir_row_t d;
    d.c     = '{mode: m, position: p[4:0], value: v[15:0]};
    d.typed = 1'b1;
    d.r     = '{status: st, value_out: vo[15:0], length: l[4:0], removed: rm[4:0]};
    return d;
  endfunction

  function automatic dir_row_t row_pred(input logic [2:0] m, input int p, input int v);
    dir_row_t d;
    d.c     = '{mode: m, position: p[4:0], value: v[15:0]};
    d.typed = 1'b0;
    d.r     = '0;
    return d;
  endfunction

  // one transaction: hold start until accepted, then record what should come back;
  // start is left high so the next call can follow without a gap
  task automatic issue_cmd(input cmd_t c, input bit typed, input rsp_t typed_rsp);
    rsp_t p;
    cmd   <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    p = predict_list_cmd(c);
    pending_rsp_q.push_back(typed ? typed_rsp : p);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    cmd   <= cmd_t'(24'($urandom));
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_mode(input int ins_weight);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_weight) return MODE_INSERT;
    r = $urandom_range(0, 99);
    if (r < 2)  return MODE_UNUSED;
    if (r < 6)  return MODE_CLEAR;
    if (r < 28) return MODE_REM_AT;
    if (r < 46) return MODE_RETRIEVE;
    if (r < 64) return MODE_REM_UNIQUE;
    if (r < 82) return MODE_REM_LAST;
    return MODE_REM_ALL;
  endfunction

  function automatic cmd_t rand_cmd(input int ins_weight);
    cmd_t c;
    c.mode = pick_mode(ins_weight);
    if ($urandom_range(0, 9) == 0) c.position = 5'($urandom_range(0, 31));
    else if (c.mode == MODE_INSERT) c.position = 5'($urandom_range(0, list_len));
    else c.position = (list_len == 0) ? 5'd0 : 5'($urandom_range(0, list_len - 1));
    // mostly a small pool of values so searches find duplicates
    if ($urandom_range(0, 7) == 0) c.value = 16'($urandom);
    else c.value = val_pool[$urandom_range(0, 5)];
    return c;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", result));
      end else begin
        want = pending_rsp_q.pop_front();
        if (result.status !== want.status)
          report_mismatch($sformatf("status got %0d exp %0d", result.status, want.status));
        if (result.value_out !== want.value_out)
          report_mismatch($sformatf("value_out got %h exp %h",
                                    result.value_out, want.value_out));
        if (result.length !== want.length)
          report_mismatch($sformatf("length got %0d exp %0d", result.length, want.length));
        if (result.removed !== want.removed)
          report_mismatch($sformatf("removed got %0d exp %0d", result.removed, want.removed));
      end
    end
  end

  initial begin
    int ins_w [N_PHASES];
    int k, ph, n;
    ins_w = '{70, 50, 35, 80, 25, 60, 45, 55};

    dir_rows = '{
      row_typed(MODE_RETRIEVE,    0, 0,       ST_RANGE,  0,       0, 0),
      row_typed(MODE_REM_AT,      0, 0,       ST_RANGE,  0,       0, 0),
      row_typed(MODE_REM_UNIQUE,  0, 5,       ST_ABSENT, 0,       0, 0),
      row_typed(MODE_REM_LAST,    0, 5,       ST_ABSENT, 0,       0, 0),
      row_typed(MODE_REM_ALL,     0, 5,       ST_OK,     0,       0, 0),
      row_typed(MODE_CLEAR,       0, 0,       ST_OK,     0,       0, 0),
      row_typed(MODE_UNUSED,      3, 16'hA5A5, ST_RANGE, 0,       0, 0),
      row_typed(MODE_INSERT,      1, 3,       ST_RANGE,  0,       0, 0),
      row_typed(MODE_INSERT,      0, 16'hFFFF, ST_OK,    0,       1, 0),
      row_typed(MODE_INSERT,      1, 0,       ST_OK,     0,       2, 0),
      row_typed(MODE_INSERT,      0, 16'hFFFF, ST_OK,    0,       3, 0),
      row_typed(MODE_RETRIEVE,    2, 0,       ST_OK,     0,       3, 0),
      row_typed(MODE_REM_UNIQUE,  0, 16'hFFFF, ST_MULTI, 0,       3, 0),
      row_typed(MODE_REM_LAST,    0, 16'hFFFF, ST_OK,    16'hFFFF, 2, 1),
      row_typed(MODE_REM_UNIQUE,  0, 0,       ST_OK,     0,       1, 1),
      row_typed(MODE_INSERT,      31, 1234,   ST_RANGE,  0,       1, 0),
      row_typed(MODE_REM_ALL,     0, 16'hFFFF, ST_OK,    16'hFFFF, 0, 1),
      row_pred (MODE_INSERT,      0, 7),
      row_pred (MODE_INSERT,      0, 7),
      row_pred (MODE_INSERT,      1, 9),
      row_typed(MODE_REM_ALL,     0, 7,       ST_OK,     7,       1, 2),
      row_pred (MODE_INSERT,      1, 8),
      row_typed(MODE_REM_AT,      0, 0,       ST_OK,     9,       1, 1),
      row_typed(MODE_CLEAR,       0, 0,       ST_OK,     0,       0, 1),
      row_typed(MODE_RETRIEVE,    31, 0,      ST_RANGE,  0,       0, 0)
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      issue_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);
      if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 5));
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      for (k = 0; k < 6; k++) val_pool[k] = 16'($urandom);
      if (ph % 2 == 0) begin
        val_pool[0] = 16'h0000;
        val_pool[1] = 16'hFFFF;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        issue_cmd(rand_cmd(ins_w[ph]), 1'b0, '0);
        // last phase runs back to back
        if (ph < N_PHASES - 1 && $urandom_range(0, 3) == 0)
          idle_cycles($urandom_range(1, 5));
      end
    end
    start <= 1'b0;

    n = 0;
    while (pending_rsp_q.size() != 0 && n < 2000) begin
      @(posedge clk);
      n++;
    end
    repeat (50) @(posedge clk);
    if (pending_rsp_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_rsp_q.size()));

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
